// File: src/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

// Property must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

`endif

// File: src/fpk_pkg.sv
// Package for the fixed-point Kalman core: types, constants, micro-op table.
// No dependencies.
package fpk_pkg;

  localparam int unsigned NumCfg   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned UopIdxW  = 5;

  localparam logic signed [15:0] MeasNoise = 16'sd12544;
  localparam logic [31:0]        GainNum   = 32'd4194304;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_TIME, REG_HALF_STEP_SQ, REG_NOISE_PP, REG_NOISE_PS,
    REG_NOISE_PA, REG_NOISE_SS, REG_NOISE_SA, REG_NOISE_AA
  } cfg_reg_e;

  // Request opcodes.
  typedef enum logic {OP_LOAD, OP_STEP} op_e;

  // Request and estimate payloads.
  typedef struct packed {
    op_e                op;
    logic signed [15:0] meas_pos;
    logic signed [15:0] load_speed;
    logic signed [15:0] load_acc;
    logic [14:0]        meas_precision;
  } kf_req_t;

  typedef struct packed {
    logic signed [15:0] est_position;
    logic signed [15:0] est_speed;
    logic signed [15:0] est_accel;
    logic signed [15:0] position_gain;
  } kf_est_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_NOISE, ST_START, ST_DIV, ST_DONE
  } fsm_state_e;

  // Register file slots of the datapath.
  typedef enum logic [3:0] {
    R_POS, R_SPD, R_ACC, R_PP, R_PS, R_PA, R_SS, R_SA, R_AA,
    R_T21, R_T22, R_S, R_GAIN, R_K1, R_K2, R_Y
  } reg_sel_e;

  // Operand A sources beyond the register file.
  typedef enum logic [1:0] {
    A_REG, A_DT, A_HDT2
  } opa_e;

  // Accumulate mode: dst = dst + p, dst - p, dst = p, or innovation (meas - pos).
  typedef enum logic [1:0] {
    M_ADD, M_SUB, M_SET, M_INNOV
  } mode_e;

  typedef struct packed {
    opa_e       asel;
    reg_sel_e   areg;
    reg_sel_e   breg;
    logic [4:0] shift;
    reg_sel_e   dst;
    mode_e      mode;
  } uop_t;

  typedef struct packed {
    logic                capture;
    logic                load;
    logic                mac_en;
    logic [UopIdxW-1:0]  uop_idx;
    logic                noise_en;
    logic                div_start;
    logic                div_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  function automatic uop_t mk(opa_e a, reg_sel_e ar, reg_sel_e br, int unsigned sh,
                              reg_sel_e d, mode_e m);
    uop_t u;
    u.asel = a; u.areg = ar; u.breg = br; u.shift = 5'(sh); u.dst = d; u.mode = m;
    return u;
  endfunction

  // Micro-ops before the division (indexes 0..16) and after it (17..29).
  // The t21 and t22 terms bypass the multiplier: the datapath adds them directly.
  function automatic uop_t uop_rom(logic [UopIdxW-1:0] i);
    uop_t u;
    u = mk(A_REG, R_POS, R_POS, 0, R_Y, M_ADD);
    case (i)
      5'd0:  u = mk(A_DT,   R_POS, R_SPD, 10, R_POS, M_ADD);
      5'd1:  u = mk(A_HDT2, R_POS, R_ACC, 16, R_POS, M_ADD);
      5'd2:  u = mk(A_DT,   R_POS, R_ACC, 14, R_SPD, M_ADD);
      5'd3:  u = mk(A_DT,   R_POS, R_PS,  10, R_PP,  M_ADD);
      5'd4:  u = mk(A_HDT2, R_POS, R_PA,  15, R_PP,  M_ADD);
      5'd5:  u = mk(A_DT,   R_POS, R_SS,  11, R_PS,  M_ADD);
      5'd6:  u = mk(A_HDT2, R_POS, R_SA,  19, R_PS,  M_ADD);
      5'd7:  u = mk(A_DT,   R_POS, R_SA,   9, R_T21, M_SET);
      5'd8:  u = mk(A_DT,   R_POS, R_AA,  11, R_T22, M_SET);
      5'd9:  u = mk(A_REG,  R_T21, R_T21, 1,  R_PA,  M_ADD); // t21 >> 1 (special)
      5'd10: u = mk(A_HDT2, R_POS, R_T22, 16, R_PA,  M_ADD);
      5'd11: u = mk(A_REG,  R_T21, R_T21, 3,  R_SS,  M_ADD); // t21 >> 3 (special)
      5'd12: u = mk(A_REG,  R_T22, R_T22, 0,  R_SA,  M_ADD); // plus t22 (special)
      5'd13: u = mk(A_DT,   R_POS, R_PS,  10, R_PP,  M_ADD);
      5'd14: u = mk(A_HDT2, R_POS, R_PA,  15, R_PP,  M_ADD);
      5'd15: u = mk(A_DT,   R_POS, R_PA,  13, R_PS,  M_ADD);
      5'd16: u = mk(A_DT,   R_POS, R_SA,  12, R_SS,  M_ADD);
      5'd17: u = mk(A_REG,  R_PP,  R_S,   12, R_GAIN, M_SET);
      5'd18: u = mk(A_REG,  R_PS,  R_S,    8, R_K1,  M_SET);
      5'd19: u = mk(A_REG,  R_PA,  R_S,    8, R_K2,  M_SET);
      5'd20: u = mk(A_REG,  R_POS, R_POS,  0, R_Y,   M_INNOV);
      5'd21: u = mk(A_REG,  R_GAIN, R_Y,  10, R_POS, M_ADD);
      5'd22: u = mk(A_REG,  R_K1,  R_Y,   14, R_SPD, M_ADD);
      5'd23: u = mk(A_REG,  R_K2,  R_Y,   13, R_ACC, M_ADD);
      5'd24: u = mk(A_REG,  R_GAIN, R_PP, 10, R_PP,  M_SUB);
      5'd25: u = mk(A_REG,  R_GAIN, R_PS, 10, R_PS,  M_SUB);
      5'd26: u = mk(A_REG,  R_GAIN, R_PA, 10, R_PA,  M_SUB);
      5'd27: u = mk(A_REG,  R_K1,  R_PS,  13, R_SS,  M_SUB);
      5'd28: u = mk(A_REG,  R_K1,  R_PA,  14, R_SA,  M_SUB);
      5'd29: u = mk(A_REG,  R_K2,  R_PA,  16, R_AA,  M_SUB);
      default: u = mk(A_REG, R_POS, R_POS, 0, R_Y, M_ADD);
    endcase
    return u;
  endfunction

  localparam logic [UopIdxW-1:0] UopLastPredict = 5'd16;
  localparam logic [UopIdxW-1:0] UopLast        = 5'd29;

endpackage

// File: src/fpk_stream_if.sv
// Valid/ready stream interface carrying one payload type.
// Depends on nothing.
interface fpk_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/fixed_point_kalman_pos_vel_acc_core.sv
// Three-state (position, speed, acceleration) fixed-point Kalman filter core.
// Depends on fpk_pkg, fpk_stream_if, fpk_ctrl, fpk_datapath, fpk_divider.
//
// One request at a time. A load request (op 0) writes the three estimates at
// acceptance and offers its result on the next cycle. A filter step (op 1)
// latches the measurement and precision at acceptance, then runs 17 predict
// micro-ops through the one shared 16x16 multiply-shift-accumulate unit (one
// per cycle), adds the process noise, starts the divider, waits for the
// restoring divider (32 quotient bits, then a done pulse), runs 13 update
// micro-ops, and then offers the result. The next request is accepted only
// after the result is taken and the controller is back in its idle state.
// The divider's one-bit-per-cycle loop sets about half of the step time.
// While a result waits it holds steady and no request is accepted.
// Configuration writes are taken at any time and should only happen while
// idle.
`include "assert_macros.svh"
module fixed_point_kalman_pos_vel_acc_core import fpk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  fpk_stream_if.sink          in_if,
  fpk_stream_if.source        out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [CfgDataW-1:0] cfg_q [NumCfg];
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ctl_ready, ctl_valid;

  // Configuration registers with their reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_STEP_TIME] <= 15'd164; cfg_q[REG_HALF_STEP_SQ] <= 15'd52;
      cfg_q[REG_NOISE_PP]  <= 15'd0;   cfg_q[REG_NOISE_PS]     <= 15'd0;
      cfg_q[REG_NOISE_PA]  <= 15'd3;   cfg_q[REG_NOISE_SS]     <= 15'd1;
      cfg_q[REG_NOISE_SA]  <= 15'd36;  cfg_q[REG_NOISE_AA]     <= 15'd458;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  fpk_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_op_i(in_if.data.op), .in_ready_o(ctl_ready),
    .out_valid_o(ctl_valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  fpk_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_i(cfg_q),
    .meas_pos_i(in_if.data.meas_pos), .load_speed_i(in_if.data.load_speed),
    .load_acc_i(in_if.data.load_acc), .meas_precision_i(in_if.data.meas_precision),
    .est_position_o(out_if.data.est_position), .est_speed_o(out_if.data.est_speed),
    .est_accel_o(out_if.data.est_accel), .position_gain_o(out_if.data.position_gain)
  );

  assign in_if.ready  = ctl_ready;
  assign out_if.valid = ctl_valid;

  `ASSERT_SAME(a_no_accept_busy, clk_i, rst_ni, out_if.valid, !in_if.ready,
    "input accepted while result pending")
  `ASSERT_NEXT(a_result_stable, clk_i, rst_ni, out_if.valid && !out_if.ready,
    $stable(out_if.data), "result changed while waiting")
  `ASSERT_SAME(a_load_on_accept, clk_i, rst_ni, cmd.load, in_if.valid && in_if.ready,
    "load without an accepted request")
endmodule

// File: src/fpk_divider.sv
// Restoring divider: 32-bit unsigned numerator by 32-bit divisor, one bit a cycle.
// Depends on fpk_pkg.
module fpk_divider import fpk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[31:0], quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i; den_d = den_i; cnt_d = 6'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// File: src/fpk_datapath.sv
// Datapath: state registers, shared multiply-shift-accumulate unit, divider.
// Depends on fpk_pkg and fpk_divider.
module fpk_datapath import fpk_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic [CfgDataW-1:0]      cfg_i [NumCfg],
  input  logic signed [15:0]       meas_pos_i,
  input  logic signed [15:0]       load_speed_i,
  input  logic signed [15:0]       load_acc_i,
  input  logic [14:0]              meas_precision_i,
  output logic signed [15:0]       est_position_o,
  output logic signed [15:0]       est_speed_o,
  output logic signed [15:0]       est_accel_o,
  output logic signed [15:0]       position_gain_o
);
  localparam logic signed [15:0] RfInit [16] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd2560, 16'sd2080, 16'sd4800, 16'sd6000, 16'sd7500,
    16'sd9375, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  logic signed [15:0] rf_q [16];
  logic signed [15:0] rf_d [16];
  uop_t               u;
  logic signed [15:0] opa, opb, res;
  logic signed [31:0] prod, psh;
  logic signed [17:0] den_s;
  logic [31:0]        den;
  logic [31:0]        quot;
  logic               div_done;
  logic signed [15:0] meas_q;
  logic [14:0]        prec_q;

  assign u = uop_rom(cmd_i.uop_idx);

  // Measurement and precision are held for the whole step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q <= '0; prec_q <= '0;
    end else if (cmd_i.capture) begin
      meas_q <= meas_pos_i; prec_q <= meas_precision_i;
    end
  end

  always_comb begin
    case (u.asel)
      A_DT:    opa = signed'({1'b0, cfg_i[REG_STEP_TIME]});
      A_HDT2:  opa = signed'({1'b0, cfg_i[REG_HALF_STEP_SQ]});
      default: opa = rf_q[u.areg];
    endcase
    opb  = rf_q[u.breg];
    prod = opa * opb;
    psh  = prod >>> u.shift;
  end

  always_comb begin
    logic is_t21, is_t22;
    is_t21 = (u.asel == A_REG) && (u.areg == R_T21);
    is_t22 = (u.asel == A_REG) && (u.areg == R_T22);
    res = rf_q[u.dst];
    if (is_t21)      res = rf_q[u.dst] + (rf_q[R_T21] >>> u.shift);
    else if (is_t22) res = rf_q[u.dst] + rf_q[R_T22];
    else begin
      case (u.mode)
        M_ADD:   res = rf_q[u.dst] + psh[15:0];
        M_SUB:   res = rf_q[u.dst] - psh[15:0];
        M_SET:   res = psh[15:0];
        M_INNOV: res = meas_q - rf_q[R_POS];
        default: res = rf_q[u.dst];
      endcase
    end
  end

  // Divisor: cov_pp + 12544 + precision*16, clamped to at least one.
  assign den_s = 18'(rf_q[R_PP]) + 18'(MeasNoise);
  always_comb begin
    logic signed [20:0] sum;
    sum = 21'(den_s) + signed'({2'b0, prec_q, 4'b0});
    den = (sum < 21'sd1) ? 32'd1 : 32'(sum);
  end

  fpk_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(GainNum), .den_i(den),
    .done_o(div_done), .quot_o(quot)
  );
  assign sts_o.div_done = div_done;

  always_comb begin
    rf_d = rf_q;
    if (cmd_i.load) begin
      rf_d[R_POS] = meas_pos_i; rf_d[R_SPD] = load_speed_i; rf_d[R_ACC] = load_acc_i;
      rf_d[R_GAIN] = '0;
    end else if (cmd_i.mac_en) begin
      rf_d[u.dst] = res;
    end else if (cmd_i.noise_en) begin
      rf_d[R_PP] = rf_q[R_PP] + 16'(cfg_i[REG_NOISE_PP]);
      rf_d[R_PS] = rf_q[R_PS] + 16'(cfg_i[REG_NOISE_PS]);
      rf_d[R_PA] = rf_q[R_PA] + 16'(cfg_i[REG_NOISE_PA]);
      rf_d[R_SS] = rf_q[R_SS] + 16'(cfg_i[REG_NOISE_SS]);
      rf_d[R_SA] = rf_q[R_SA] + 16'(cfg_i[REG_NOISE_SA]);
      rf_d[R_AA] = rf_q[R_AA] + 16'(cfg_i[REG_NOISE_AA]);
    end else if (cmd_i.div_wr) begin
      rf_d[R_S] = quot[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= RfInit;
    end else begin
      rf_q <= rf_d;
    end
  end

  assign est_position_o  = rf_q[R_POS];
  assign est_speed_o     = rf_q[R_SPD];
  assign est_accel_o     = rf_q[R_ACC];
  assign position_gain_o = rf_q[R_GAIN];
endmodule

// File: src/fpk_ctrl.sv
// Controller FSM: sequences load, micro-ops, noise add, division, result.
// Depends on fpk_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fpk_ctrl import fpk_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  op_e     in_op_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);
  fsm_state_e         state_q, state_d;
  logic [UopIdxW-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q; idx_d = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          state_d = (in_op_i == OP_STEP) ? ST_MAC : ST_DONE;
        end
      end
      ST_MAC: begin
        idx_d = idx_q + 5'd1;
        if (idx_q == UopLastPredict) state_d = ST_NOISE;
        else if (idx_q == UopLast) state_d = ST_DONE;
      end
      ST_NOISE: state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV: if (sts_i.div_done) state_d = ST_MAC;
      ST_DONE: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.uop_idx = idx_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
        cmd_o.load = in_valid_i && (in_op_i == OP_LOAD);
      end
      ST_MAC: cmd_o.mac_en = 1'b1;
      ST_NOISE: cmd_o.noise_en = 1'b1;
      ST_START: cmd_o.div_start = 1'b1;
      ST_DIV: cmd_o.div_wr = sts_i.div_done;
      ST_DONE: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; idx_q <= '0;
    end else begin
      state_q <= state_d; idx_q <= idx_d;
    end
  end

  `ASSERT_NEXT(a_start_after_noise, clk_i, rst_ni, state_q == ST_NOISE,
    cmd_o.div_start, "divider not started after noise add")
  `ASSERT_SAME(a_mac_idx, clk_i, rst_ni, cmd_o.mac_en, idx_q <= UopLast,
    "micro-op index out of range")
  `ASSERT_NEXT(a_done_holds, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o, "result dropped before taken")
  `ASSERT_SAME(a_idle_ready, clk_i, rst_ni, in_ready_o, !out_valid_o,
    "ready while result pending")
endmodule
